// ===== rtl/core/tsq_pkg.sv =====
`default_nettype none
package tsq_pkg;

	localparam int MUSIC_DEPTH = 32;
	localparam int SOUND_DEPTH = 32;
	localparam int MUSIC_AW    = $clog2(MUSIC_DEPTH);
	localparam int SOUND_AW    = $clog2(SOUND_DEPTH);
	// sound position and fill count must also hold the depth itself
	localparam int SOUND_CW    = $clog2(SOUND_DEPTH + 1);

	// music word: {period, length[15:0]}, sound word: {period, length[7:0]}
	localparam int MUSIC_WORD_W = 32;
	localparam int SOUND_WORD_W = 24;

	localparam logic [15:0] REST_CODE = 16'hFFFF;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_PUSH   = 3'd1;
	localparam logic [2:0] ACT_CLEAR  = 3'd2;
	localparam logic [2:0] ACT_APPEND = 3'd3;
	localparam logic [2:0] ACT_START  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_CUR,
		ST_RD_NXT,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/tsq_ram.sv =====
`default_nettype none
module tsq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tone_sequencer_two_queues_core.sv =====
`default_nettype none
// Tone sequencer with a music ring and a sound-effect store, each held in a
// one-port-read RAM with registered read data. Every input word (tick, music
// push, sound clear, sound append, sound start) passes through the states in
// order: it is accepted in ST_IDLE, the RAM is read in ST_RD_CUR (current entry)
// and ST_RD_NXT (next entry or entry zero), and ST_FIN updates the pointers,
// writes the RAM and loads the result register. in_stall is high from ST_RD_CUR
// through ST_FIN, and ST_FIN also waits while a previous result is still stalled at the
// output. Ticks drive tone_enable and tone_period; sound plays over music while
// the music ring keeps advancing silently. The user must write clock_adjust through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it. No
// clearing pass follows reset: RAM data is only used after it is written.
module tone_sequencer_two_queues_core
	import tsq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] period,
	input  wire logic [15:0] length,
	input  wire logic [15:0] repeat_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             tone_enable,
	output logic [15:0]      tone_period,
	output logic             sound_active,
	output logic [4:0]       music_remaining,
	output logic             accepted
);

	state_t state_q, state_d;

	logic [2:0]  act_q;
	logic [15:0] period_q;
	logic [15:0] length_q;
	logic [15:0] repeat_q;
	logic        clock_adjust_q;

	logic [MUSIC_AW-1:0] m_head_q, m_tail_q, m_head_d, m_tail_d;
	logic [15:0]         m_wait_q, m_wait_d;
	logic [SOUND_CW-1:0] s_pos_q, s_end_q, s_fill_q, s_pos_d, s_end_d, s_fill_d;
	logic [7:0]          s_wait_q, s_wait_d;
	logic [15:0]         s_rep_q, s_rep_d;

	logic [15:0] sp_cur_q, mp_cur_q;

	logic        out_valid_q, tone_enable_q, sound_active_q, accepted_q;
	logic [15:0] tone_period_q;
	logic [4:0]  music_remaining_q;
	logic        enable_d, accepted_d;
	logic [15:0] tone_period_d;
	logic [4:0]  remaining_d;

	logic fin_go;

	logic                    s_we, s_re, m_we, m_re;
	logic [SOUND_AW-1:0]     s_raddr, s_waddr;
	logic [MUSIC_AW-1:0]     m_raddr;
	logic [SOUND_WORD_W-1:0] s_wdata, s_rdata;
	logic [MUSIC_WORD_W-1:0] m_wdata, m_rdata;

	logic [SOUND_CW-1:0] s_np;
	logic                s_wrap, s_playing, m_playing;
	logic [MUSIC_AW-1:0] m_nh, m_nt;
	logic [16:0]         p_plus7;
	logic [15:0]         p_adj, p_scaled;
	logic [15:0]         p_play;
	logic                playing;
	logic [MUSIC_AW:0]   m_count;

	assign in_stall = (state_q != ST_IDLE);

	assign s_playing = (s_pos_q != s_end_q);
	assign m_playing = (m_head_q != m_tail_q);
	assign s_np      = s_pos_q + SOUND_CW'(1);
	assign s_wrap    = (s_np == s_end_q) || (s_np >= SOUND_CW'(SOUND_DEPTH));
	assign m_nh      = (m_head_q == MUSIC_AW'(MUSIC_DEPTH - 1)) ? '0 : m_head_q + MUSIC_AW'(1);
	assign m_nt      = (m_tail_q == MUSIC_AW'(MUSIC_DEPTH - 1)) ? '0 : m_tail_q + MUSIC_AW'(1);

	// 15/16 scaling (clock_adjust only) rounds the removed part to nearest, then drop one; 0 becomes a rest
	assign p_plus7  = {1'b0, period_q} + 17'd7;
	assign p_adj    = clock_adjust_q ? period_q - 16'(p_plus7[16:4]) : period_q;
	assign p_scaled = p_adj - 16'd1;

	assign s_we    = fin_go && (act_q == ACT_APPEND) && (s_fill_q < SOUND_CW'(SOUND_DEPTH));
	assign s_waddr = s_fill_q[SOUND_AW-1:0];
	assign s_wdata = {p_scaled, length_q[7:0]};
	assign m_we    = fin_go && (act_q == ACT_PUSH) && (m_nt != m_head_q);
	assign m_wdata = {p_scaled, length_q};

	tsq_ram #(.WIDTH(SOUND_WORD_W), .DEPTH(SOUND_DEPTH)) u_sound_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	tsq_ram #(.WIDTH(MUSIC_WORD_W), .DEPTH(MUSIC_DEPTH)) u_music_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_tail_q),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fin_go  = 1'b0;
		s_re    = 1'b0;
		m_re    = 1'b0;
		s_raddr = s_pos_q[SOUND_AW-1:0];
		m_raddr = m_head_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RD_CUR;
				end
			end
			ST_RD_CUR: begin
				s_re    = 1'b1;
				m_re    = 1'b1;
				state_d = ST_RD_NXT;
			end
			ST_RD_NXT: begin
				// next entry, or entry zero on wrap and on start
				s_re    = 1'b1;
				m_re    = 1'b1;
				s_raddr = ((act_q == ACT_START) || s_wrap) ? '0 : s_np[SOUND_AW-1:0];
				m_raddr = m_nh;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		m_head_d      = m_head_q;
		m_tail_d      = m_tail_q;
		m_wait_d      = m_wait_q;
		s_pos_d       = s_pos_q;
		s_end_d       = s_end_q;
		s_fill_d      = s_fill_q;
		s_wait_d      = s_wait_q;
		s_rep_d       = s_rep_q;
		accepted_d    = 1'b0;
		p_play        = REST_CODE;
		playing       = 1'b0;
		case (act_q)
			ACT_TICK: begin
				if (s_playing || m_playing) begin
					playing = 1'b1;
					p_play  = s_playing ? sp_cur_q : mp_cur_q;
				end
				if (s_playing) begin
					if (s_wait_q <= 8'd1) begin
						if (s_wrap) begin
							s_pos_d = '0;
							if (s_rep_q > 16'd1) begin
								s_rep_d  = s_rep_q - 16'd1;
								s_wait_d = s_rdata[7:0];
							end else begin
								s_end_d  = '0;
								s_rep_d  = '0;
								s_wait_d = '0;
							end
						end else begin
							s_pos_d  = s_np;
							s_wait_d = s_rdata[7:0];
						end
					end else begin
						s_wait_d = s_wait_q - 8'd1;
					end
				end
				if (m_playing) begin
					if (m_wait_q <= 16'd1) begin
						m_head_d = m_nh;
						m_wait_d = (m_nh != m_tail_q) ? m_rdata[15:0] : 16'd0;
					end else begin
						m_wait_d = m_wait_q - 16'd1;
					end
				end
			end
			ACT_PUSH: begin
				if (m_nt != m_head_q) begin
					if (!m_playing) begin
						m_wait_d = length_q;
					end
					m_tail_d   = m_nt;
					accepted_d = 1'b1;
				end
			end
			ACT_CLEAR: begin
				s_pos_d    = '0;
				s_end_d    = '0;
				s_wait_d   = '0;
				s_rep_d    = '0;
				s_fill_d   = '0;
				accepted_d = 1'b1;
			end
			ACT_APPEND: begin
				if (s_fill_q < SOUND_CW'(SOUND_DEPTH)) begin
					s_fill_d   = s_fill_q + SOUND_CW'(1);
					accepted_d = 1'b1;
				end
			end
			ACT_START: begin
				s_pos_d    = '0;
				s_end_d    = s_fill_q;
				accepted_d = 1'b1;
				if (s_fill_q != '0) begin
					s_rep_d  = repeat_q;
					s_wait_d = s_rdata[7:0];
				end else begin
					s_rep_d  = '0;
					s_wait_d = '0;
				end
			end
			default: begin
			end
		endcase
		enable_d      = playing && (p_play != REST_CODE);
		tone_period_d = enable_d ? p_play : 16'd0;
		if (m_tail_d >= m_head_d) begin
			m_count = {1'b0, m_tail_d} - {1'b0, m_head_d};
		end else begin
			m_count = {1'b0, m_tail_d} + (MUSIC_AW + 1)'(MUSIC_DEPTH) - {1'b0, m_head_d};
		end
		remaining_d = 5'(m_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_adjust_q <= 1'b0;
			m_head_q       <= '0;
			m_tail_q       <= '0;
			m_wait_q       <= '0;
			s_pos_q        <= '0;
			s_end_q        <= '0;
			s_fill_q       <= '0;
			s_wait_q       <= '0;
			s_rep_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				clock_adjust_q <= cfg_wdata;
			end
			if (fin_go) begin
				m_head_q <= m_head_d;
				m_tail_q <= m_tail_d;
				m_wait_q <= m_wait_d;
				s_pos_q  <= s_pos_d;
				s_end_q  <= s_end_d;
				s_fill_q <= s_fill_d;
				s_wait_q <= s_wait_d;
				s_rep_q  <= s_rep_d;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_q    <= action;
			period_q <= period;
			length_q <= length;
			repeat_q <= repeat_count;
		end
		// keep the current periods while the next entries are read
		if (state_q == ST_RD_NXT) begin
			sp_cur_q <= s_rdata[23:8];
			mp_cur_q <= m_rdata[31:16];
		end
		if (fin_go) begin
			tone_enable_q     <= enable_d;
			tone_period_q     <= tone_period_d;
			sound_active_q    <= (s_pos_d != s_end_d);
			music_remaining_q <= remaining_d;
			accepted_q        <= accepted_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign tone_enable     = tone_enable_q;
	assign tone_period     = tone_period_q;
	assign sound_active    = sound_active_q;
	assign music_remaining = music_remaining_q;
	assign accepted        = accepted_q;

endmodule
`default_nettype wire

// ===== rtl/core/tsq_checker.sv =====
`default_nettype none
module tsq_checker
	import tsq_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        tone_enable,
	input wire logic [15:0] tone_period,
	input wire logic        accepted
);

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tone_enable |-> tone_period == 16'd0)
		else $error("period shown with tone off");

	a_no_rest_tone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tone_enable |-> tone_period != REST_CODE)
		else $error("rest code played as a tone");

	a_tick_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tone_enable |-> !accepted)
		else $error("tick result flagged accepted");

endmodule

bind tone_sequencer_two_queues_core tsq_checker u_tsq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.tone_enable (tone_enable),
	.tone_period (tone_period),
	.accepted    (accepted)
);
`default_nettype wire
